FILE: rtl/ptd_pkg.sv
package ptd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 8;
  localparam int COORD_W       = 32;
  localparam int SUM_W         = 66;
  localparam int QUO_W         = 33;
  localparam int REM_W         = SUM_W + QUO_W;
  localparam int MAC_LAT       = 2;
  localparam int DIV_LAT       = QUO_W + 3;
  localparam int PIPE_LAT      = MAC_LAT + DIV_LAT;

  typedef logic [NUM_REGS-1:0][63:0] mat_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] value;
    logic                      ovf;
    logic                      wz;
  } div_res_t;

endpackage

FILE: rtl/ptd_mac.sv
module ptd_mac #(
  parameter int FRAC_BITS = ptd_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [95:0]         point,
  input  ptd_pkg::mat_t       mat,
  output ptd_pkg::sum_t       sums [4]
);
  import ptd_pkg::*;

  logic signed [63:0] prod_r [4][3];
  sum_t               sum_r  [4];

  genvar c, r;
  generate
    for (c = 0; c < 4; c++) begin : g_col
      logic signed [31:0] m4;
      sum_t               acc;
      assign m4 = mat[6 + (c >> 1)][32*(c & 1) +: 32];
      for (r = 0; r < 3; r++) begin : g_row
        logic signed [31:0] ent;
        logic signed [31:0] p;
        assign ent = mat[r*2 + (c >> 1)][32*(c & 1) +: 32];
        assign p   = point[32*r +: 32];
        always_ff @(posedge clk) begin
          if (en) begin
            prod_r[c][r] <= p * ent;
          end
        end
      end
      assign acc = SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1]) + SUM_W'(prod_r[c][2]);
      always_ff @(posedge clk) begin
        if (en) begin
          sum_r[c] <= (acc >>> FRAC_BITS) + SUM_W'(m4);
        end
      end
      assign sums[c] = sum_r[c];
    end
  endgenerate

endmodule

FILE: rtl/ptd_div.sv
module ptd_div #(
  parameter int FRAC_BITS = ptd_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  ptd_pkg::sum_t     num,
  input  ptd_pkg::sum_t     den,
  output ptd_pkg::div_res_t res
);
  import ptd_pkg::*;

  logic [REM_W-1:0] n0_r;
  logic [SUM_W-1:0] d0_r;
  logic             neg0_r, wz0_r;

  logic [REM_W-1:0] rem_r [QUO_W+1];
  logic [QUO_W-1:0] q_r   [QUO_W+1];
  logic [SUM_W-1:0] d_r   [QUO_W+1];
  logic             neg_r [QUO_W+1];
  logic             big_r [QUO_W+1];
  logic             wz_r  [QUO_W+1];
  div_res_t         res_r;

  logic [SUM_W-1:0] n_abs, d_abs;
  assign n_abs = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
  assign d_abs = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r   <= REM_W'(n_abs) << FRAC_BITS;
      d0_r   <= d_abs;
      neg0_r <= num[SUM_W-1] ^ den[SUM_W-1];
      wz0_r  <= (den == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n0_r;
      q_r[0]   <= '0;
      d_r[0]   <= d0_r;
      neg_r[0] <= neg0_r;
      wz_r[0]  <= wz0_r;
      big_r[0] <= n0_r >= (REM_W'(d0_r) << QUO_W);
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUO_W; i++) begin : g_step
      logic [REM_W-1:0] dsh;
      logic             ge;
      assign dsh = REM_W'(d_r[i]) << (QUO_W - 1 - i);
      assign ge  = rem_r[i] >= dsh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? rem_r[i] - dsh : rem_r[i];
          q_r[i+1]   <= {q_r[i][QUO_W-2:0], ge};
          d_r[i+1]   <= d_r[i];
          neg_r[i+1] <= neg_r[i];
          wz_r[i+1]  <= wz_r[i];
          big_r[i+1] <= big_r[i];
        end
      end
    end
  endgenerate

  div_res_t         res_nxt;
  logic [QUO_W-1:0] qf;
  assign qf = q_r[QUO_W];

  always_comb begin
    res_nxt.wz = wz_r[QUO_W];
    if (wz_r[QUO_W]) begin
      res_nxt.value = '0;
      res_nxt.ovf   = 1'b0;
    end else if (!neg_r[QUO_W]) begin
      if (big_r[QUO_W] || qf > QUO_W'(32'h7FFF_FFFF)) begin
        res_nxt.value = 32'sh7FFF_FFFF;
        res_nxt.ovf   = 1'b1;
      end else begin
        res_nxt.value = qf[31:0];
        res_nxt.ovf   = 1'b0;
      end
    end else begin
      if (big_r[QUO_W] || qf > QUO_W'(32'h8000_0000)) begin
        res_nxt.value = 32'sh8000_0000;
        res_nxt.ovf   = 1'b1;
      end else begin
        res_nxt.value = -qf[31:0];
        res_nxt.ovf   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/point_transform_homogeneous_divide.sv
// channel  dir  handshake              payload (low bit up)
// in_      in   in_tvalid/in_tready    in_tdata: point_x, point_y, point_z
// out_     out  out_tvalid/out_tready  out_tdata: out_x, out_y, out_z;
//                                      out_tuser: w_zero, overflow
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data (64-bit pair of entries of one matrix row)
//
// Pipeline of 2 multiply/sum stages, 33 restoring divide steps and
// 3 setup/saturate stages; one point per cycle while the output is not stalled.
// Stall freezes the whole pipeline while the output holds and is not taken.
// rst_n clears valid bits and restores the identity matrix. cfg_ready is always high.
module point_transform_homogeneous_divide #(
  parameter int FRAC_BITS = ptd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [95:0]                   in_tdata,   // point_x, point_y, point_z
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [95:0]                   out_tdata,  // out_x, out_y, out_z
  output logic [1:0]                    out_tuser,  // w_zero, overflow
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import ptd_pkg::*;

  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  mat_t     mat_r;
  logic     en;
  logic     v_r [PIPE_LAT];
  sum_t     sums [4];
  div_res_t res [3];

  assign cfg_ready = 1'b1;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= {ONE << 32, 64'h0, ONE, 64'h0, 64'h0, ONE << 32, 64'h0, ONE};
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int k = 1; k < PIPE_LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  ptd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk   (clk),
    .en    (en),
    .point (in_tdata),
    .mat   (mat_r),
    .sums  (sums)
  );

  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_div
      ptd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk (clk),
        .en  (en),
        .num (sums[c]),
        .den (sums[3]),
        .res (res[c])
      );
      assign out_tdata[32*c +: 32] = res[c].value;
    end
  endgenerate

  assign out_tvalid   = v_r[PIPE_LAT-1];
  assign out_tuser[0] = res[0].wz;
  assign out_tuser[1] = res[0].ovf || res[1].ovf || res[2].ovf;

  a_wz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("overflow set with zero divisor");
  a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("nonzero result with zero divisor");
  a_wz_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res[0].wz == res[1].wz && res[1].wz == res[2].wz)
    else $error("divider lanes disagree on zero divisor");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

FILE: tb/tb_point_transform_homogeneous_divide.sv
`timescale 1ns / 100ps

module tb_point_transform_homogeneous_divide;
  import ptd_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    ROW1_C12, ROW1_C34, ROW2_C12, ROW2_C34,
    ROW3_C12, ROW3_C34, ROW4_C12, ROW4_C34, REG_BEYOND
  } mreg_e;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               w_zero, overflow;
  } proj_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  mat_t        matrix;
  logic [95:0] point_q[$];
  proj_t       proj_q[$];
  int          send_idle = 0, recv_idle = 0;
  int          errors = 0, cycles = 0;
  bit          pt_sent = 0;

  point_transform_homogeneous_divide dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [31:0] entry(int r, int c);
    return matrix[r*2 + c/2][32*(c%2) +: 32];
  endfunction

  function automatic proj_t project_point(logic [95:0] pt);
    logic signed [127:0] p[3];
    logic signed [127:0] s[4];
    logic signed [127:0] acc, m, q;
    logic signed [31:0]  q32[3];
    proj_t r;
    for (int i = 0; i < 3; i++) p[i] = $signed(pt[32*i +: 32]);
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        m = entry(i, c);
        acc += p[i] * m;
      end
      m = entry(3, c);
      s[c] = (acc >>> FRAC) + m;
    end
    r = '{default: 0};
    if (s[3] == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    for (int c = 0; c < 3; c++) begin
      q = (s[c] <<< FRAC) / s[3];
      if (q > 128'sd2147483647) begin
        q32[c] = POS_MAX;
        r.overflow = 1'b1;
      end else if (q < -128'sd2147483648) begin
        q32[c] = NEG_MAX;
        r.overflow = 1'b1;
      end else begin
        q32[c] = q[31:0];
      end
    end
    r.x = q32[0];
    r.y = q32[1];
    r.z = q32[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h", what, want, got);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    logic v;
    v = in_tvalid;
    if (!rst_n) begin
      v = 1'b0;
    end else if (!in_tvalid || pt_sent) begin
      v = 1'b0;
      if (point_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_tdata <= point_q.pop_front();
        v = 1'b1;
      end
    end
    in_tvalid <= v;
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    proj_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      pt_sent = rst_n && in_tvalid && in_tready;
      if (rst_n && cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        matrix[cfg_index[2:0]] = cfg_data;
      if (pt_sent) proj_q.push_back(project_point(in_tdata));
      if (rst_n && out_tvalid && out_tready) begin
        if (proj_q.size() == 0) begin
          $display("mismatch: result transfer with nothing expected");
          errors++;
        end else begin
          e = proj_q.pop_front();
          if (out_tdata[31:0] !== e.x) report_mismatch("out_x", e.x, out_tdata[31:0]);
          if (out_tdata[63:32] !== e.y) report_mismatch("out_y", e.y, out_tdata[63:32]);
          if (out_tdata[95:64] !== e.z) report_mismatch("out_z", e.z, out_tdata[95:64]);
          if (out_tuser[0] !== e.w_zero) report_mismatch("w_zero", e.w_zero, out_tuser[0]);
          if (out_tuser[1] !== e.overflow)
            report_mismatch("overflow", e.overflow, out_tuser[1]);
        end
      end
    end
  end

  task automatic write_reg(mreg_e idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (point_q.size() != 0 || in_tvalid || proj_q.size() != 0) @(negedge clk);
  endtask

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_q.push_back({z, y, x});
  endtask

  function automatic logic [31:0] rand_entry(int kind);
    logic [31:0] corner[4] = '{32'h0, POS_MAX, NEG_MAX, 32'hffff_ffff};
    case (kind)
      0: return corner[$urandom_range(3)];
      1: return $urandom();
      default: return $urandom_range(0, 2**19) - 2**18;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(int kind);
    if (kind < 2) return rand_entry(kind);
    return $urandom_range(0, 2**27 - 1) - 2**26;
  endfunction

  task automatic load_matrix(int kind);
    logic [31:0] e[16];
    for (int i = 0; i < 16; i++) e[i] = rand_entry(kind);
    if (kind >= 2) begin
      // keep the divisor's constant term near 1.0 and its coefficients small so most quotients stay in range
      e[3] = $urandom_range(0, 1310) - 655;
      e[7] = $urandom_range(0, 1310) - 655;
      e[11] = $urandom_range(0, 1310) - 655;
      e[15] = ONE + $urandom_range(0, 2**15) - 2**14;
      e[12] = $urandom();
    end
    for (int r = 0; r < 8; r++) write_reg(mreg_e'(r), {e[2*r+1], e[2*r]});
  endtask

  initial begin
    matrix = '0;
    matrix[ROW1_C12] = 64'(ONE);
    matrix[ROW2_C12] = {ONE, 32'h0};
    matrix[ROW3_C34] = 64'(ONE);
    matrix[ROW4_C34] = {ONE, 32'h0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 34;
    recv_idle = 70;

    // identity after reset
    push_point(0, 0, 0);
    push_point(POS_MAX, NEG_MAX, 32'hffff_ffff);
    push_point(NEG_MAX, POS_MAX, ONE);
    push_point(32'h1234_5678, 32'hedcb_a987, 32'h0000_0001);
    drain();

    // zero divisor
    write_reg(ROW4_C34, 64'h0);
    push_point(ONE, ONE, ONE);
    push_point(POS_MAX, NEG_MAX, POS_MAX);
    drain();

    // divisor follows x: zero, tiny, negative
    write_reg(ROW1_C34, {ONE, 32'h0});
    push_point(0, ONE, ONE);
    push_point(32'h1, POS_MAX, NEG_MAX);
    push_point(32'hffff_0000, 32'h0003_0000, 32'hfffd_0000);
    push_point(32'hffff_ffff, ONE, 32'h1);
    push_point(POS_MAX, POS_MAX, NEG_MAX);
    drain();

    // out of range index must leave the matrix alone
    write_reg(REG_BEYOND, 64'hdead_beef_dead_beef);
    push_point(32'h0002_0000, 32'h0005_8000, 32'hfff0_0000);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      send_idle = ph < 4 ? 34 : ph < 8 ? 70 : 0;
      recv_idle = ph < 4 ? 70 : ph < 8 ? 34 : 0;
      load_matrix(ph == 0 || ph == 9 ? 0 : ph == 1 || ph == 6 ? 1 : 2);
      for (int i = 0; i < 40; i++) begin
        int k;
        k = $urandom_range(9);
        k = k == 0 ? 1 : k == 1 ? 0 : 2;
        push_point(rand_coord(k), rand_coord(k), rand_coord(k));
      end
      drain();
    end

    repeat (PIPE_LAT + 10) @(negedge clk);
    if (errors == 0 && proj_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ptd_pkg.sv
rtl/ptd_mac.sv
rtl/ptd_div.sv
rtl/point_transform_homogeneous_divide.sv
tb/tb_point_transform_homogeneous_divide.sv
